[sv/assert_macros.svh]
// Assertion shorthands used by the lst_chk checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LST_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication.
`define LST_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[sv/lst_pkg.sv]
// ----------------------------------------------------------------------------
// lst_pkg
// Types and constants of the latency statistics table.
// ----------------------------------------------------------------------------
package lst_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_START = 2'd1,
        CMD_END   = 2'd2,
        CMD_QUERY = 2'd3
    } lst_cmd_t;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_SLOTS     = 2'd1;
    localparam logic [1:0] CFG_FREQUENCY = 2'd2;

    // which value the conversion sequencer is working on
    localparam logic [1:0] CONV_LAST = 2'd0;
    localparam logic [1:0] CONV_AVG  = 2'd1;
    localparam logic [1:0] CONV_MAX  = 2'd2;

    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [30:0] US_LIMIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  slot;
        logic [63:0] timestamp;
    } lst_in_t;

    typedef struct packed {
        logic [30:0] last_us;
        logic [30:0] average_us;
        logic [30:0] max_us;
    } lst_out_t;

    typedef struct packed {
        logic [63:0] start_time;
        logic [63:0] end_time;
        logic [63:0] duration_sum;
        logic [31:0] sample_count;
        logic [63:0] duration_max;
    } lst_entry_t;

    typedef struct packed {
        logic        load;
        logic        wide;      // 1: 64 quotient bits, 0: 32 quotient bits
        logic [31:0] rem_init;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } lst_div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } lst_div_rsp_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_REPLY,
        ST_EXEC,
        ST_END_D,
        ST_END_WR,
        ST_Q_DIFF,
        ST_Q_AVG,
        ST_CONV_LO,
        ST_CONV_HI,
        ST_CONV_ADD,
        ST_CONV_CHK,
        ST_CONV_DIV
    } lst_state_t;

endpackage

[sv/lst_div.sv]
// ----------------------------------------------------------------------------
// lst_div
// Restoring divider, two quotient bits per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module lst_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lst_pkg::lst_div_req_t req,
    output lst_pkg::lst_div_rsp_t rsp
);
    import lst_pkg::*;

    logic [31:0] rem_reg,  rem_next;
    logic [63:0] quo_reg,  quo_next;
    logic [31:0] dvs_reg,  dvs_next;
    logic [4:0]  step_reg, step_next;
    logic        run_reg,  run_next;
    logic        done_reg, done_next;

    logic [32:0] r1, r2;
    logic [31:0] rem1, rem2;
    logic        q1, q2;

    always_comb
    begin
        // first bit
        r1 = {rem_reg, quo_reg[63]};
        if (r1 >= {1'b0, dvs_reg})
        begin
            rem1 = 32'(r1 - {1'b0, dvs_reg});
            q1   = 1'b1;
        end
        else
        begin
            rem1 = r1[31:0];
            q1   = 1'b0;
        end
        // second bit
        r2 = {rem1, quo_reg[62]};
        if (r2 >= {1'b0, dvs_reg})
        begin
            rem2 = 32'(r2 - {1'b0, dvs_reg});
            q2   = 1'b1;
        end
        else
        begin
            rem2 = r2[31:0];
            q2   = 1'b0;
        end

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (req.load)
        begin
            rem_next  = req.rem_init;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            step_next = req.wide ? 5'd31 : 5'd15;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = rem2;
            quo_next  = {quo_reg[61:0], q1, q2};
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[sv/latency_stats_table.sv]
// ----------------------------------------------------------------------------
// latency_stats_table
// Per-slot latency statistics kept in one RAM, read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Disabled commands and bad slots get only a zero reply; a clear zeroes the
// slots in use; a query runs the average division (64 quotient bits, only when
// samples exist) and three conversions on the shared radix-4 divider.
// One command in flight at a time; busy is high until its result beat.
// After reset a clearing pass zeroes every RAM entry with busy high;
// config writes are taken during it.
module latency_stats_table #(
    parameter int SLOTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lst_pkg::lst_in_t request,
    output logic             done,
    output lst_pkg::lst_out_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import lst_pkg::*;

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = ($clog2(SLOTS + 1) > 6) ? $clog2(SLOTS + 1) : 6;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    // configuration
    logic        enable_reg;
    logic [5:0]  slots_in_use_reg;
    logic [31:0] freq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            slots_in_use_reg <= 6'd32;
            freq_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:    enable_reg       <= cfg_data[0];
                CFG_SLOTS:     slots_in_use_reg <= cfg_data[5:0];
                CFG_FREQUENCY: freq_reg         <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // statistics RAM
    lst_entry_t             mem [SLOTS];
    lst_entry_t             rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [ADDR_W-1:0]      mem_raddr;
    lst_entry_t             mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // divider
    lst_div_req_t div_req;
    lst_div_rsp_t div_rsp;

    lst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer state
    lst_state_t       state_reg, state_next;
    lst_in_t          req_reg,   req_next;
    lst_entry_t       entry_reg, entry_next;
    logic [63:0]      d_reg,     d_next;
    logic [63:0]      avg_reg,   avg_next;
    logic [51:0]      p_lo_reg,  p_lo_next;
    logic [51:0]      p_hi_reg,  p_hi_next;
    logic [83:0]      n_reg,     n_next;
    logic [1:0]       idx_reg,   idx_next;
    lst_out_t         acc_reg,   acc_next;
    lst_out_t         result_reg, result_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;

    logic [CNT_W-1:0] siu_ext;
    logic [CNT_W-1:0] clr_limit;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] in_slot_ext;
    logic [CNT_W-1:0] req_slot_ext;
    logic             in_range;
    logic [63:0]      sel_ticks;
    logic             store_en;
    logic [30:0]      store_val;

    assign siu_ext      = CNT_W'(slots_in_use_reg);
    assign clr_limit    = (siu_ext > SLOTS_C) ? SLOTS_C : siu_ext;
    assign cnt_inc      = cnt_reg + CNT_W'(1);
    assign in_slot_ext  = CNT_W'(request.slot);
    assign req_slot_ext = CNT_W'(req_reg.slot);
    assign in_range     = in_slot_ext < SLOTS_C;

    assign mem_raddr = (state_reg == ST_IDLE) ? in_slot_ext[ADDR_W-1:0]
                                              : req_slot_ext[ADDR_W-1:0];

    always_comb
    begin
        case (idx_reg)
            CONV_LAST: sel_ticks = d_reg;
            CONV_AVG:  sel_ticks = avg_reg;
            default:   sel_ticks = entry_reg.duration_max;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        entry_next  = entry_reg;
        d_next      = d_reg;
        avg_next    = avg_reg;
        p_lo_next   = p_lo_reg;
        p_hi_next   = p_hi_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mem_we      = 1'b0;
        mem_waddr   = req_slot_ext[ADDR_W-1:0];
        mem_wdata   = entry_reg;
        div_req     = '0;
        store_en    = 1'b0;
        store_val   = '0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = '0;
                cnt_next  = cnt_inc;
                if (cnt_inc == SLOTS_C)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    cnt_next = '0;
                    if (!enable_reg)
                        state_next = ST_REPLY;
                    else if (request.cmd == CMD_CLEAR)
                        state_next = (clr_limit == '0) ? ST_REPLY : ST_CLEAR;
                    else if (!in_range)
                        state_next = ST_REPLY;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = '0;
                cnt_next  = cnt_inc;
                if (cnt_inc == clr_limit)
                    state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                result_next = '0;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_EXEC:
            begin
                entry_next = rd_data_reg;
                case (req_reg.cmd)
                    CMD_START:
                    begin
                        mem_we               = 1'b1;
                        mem_wdata            = rd_data_reg;
                        mem_wdata.start_time = req_reg.timestamp;
                        state_next           = ST_REPLY;
                    end
                    CMD_END:   state_next = ST_END_D;
                    CMD_QUERY: state_next = ST_Q_DIFF;
                    default:   state_next = ST_REPLY;
                endcase
            end
            ST_END_D:
            begin
                d_next     = req_reg.timestamp - entry_reg.start_time;
                state_next = ST_END_WR;
            end
            ST_END_WR:
            begin
                mem_we                 = 1'b1;
                mem_wdata              = entry_reg;
                mem_wdata.end_time     = req_reg.timestamp;
                mem_wdata.duration_sum = entry_reg.duration_sum + d_reg;
                if (entry_reg.sample_count != '1)
                    mem_wdata.sample_count = entry_reg.sample_count + 32'd1;
                if (entry_reg.duration_max < d_reg)
                    mem_wdata.duration_max = d_reg;
                state_next = ST_REPLY;
            end
            ST_Q_DIFF:
            begin
                d_next   = entry_reg.end_time - entry_reg.start_time;
                acc_next = '0;
                idx_next = CONV_LAST;
                if (entry_reg.sample_count != '0)
                begin
                    div_req.load     = 1'b1;
                    div_req.wide     = 1'b1;
                    div_req.rem_init = '0;
                    div_req.dividend = entry_reg.duration_sum;
                    div_req.divisor  = entry_reg.sample_count;
                    state_next       = ST_Q_AVG;
                end
                else
                begin
                    avg_next   = '0;
                    state_next = ST_CONV_LO;
                end
            end
            ST_Q_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient;
                    state_next = ST_CONV_LO;
                end
            end
            ST_CONV_LO:
            begin
                p_lo_next  = sel_ticks[31:0] * US_PER_S;
                state_next = ST_CONV_HI;
            end
            ST_CONV_HI:
            begin
                p_hi_next  = sel_ticks[63:32] * US_PER_S;
                state_next = ST_CONV_ADD;
            end
            ST_CONV_ADD:
            begin
                n_next     = {p_hi_reg, 32'b0} + 84'(p_lo_reg);
                state_next = ST_CONV_CHK;
            end
            ST_CONV_CHK:
            begin
                if (freq_reg == '0)
                begin
                    store_en  = 1'b1;
                    store_val = '0;
                end
                else if (n_reg[83:31] >= 53'(freq_reg))
                begin
                    // quotient would not fit in 31 bits
                    store_en  = 1'b1;
                    store_val = US_LIMIT;
                end
                else
                begin
                    // top bits are below the divisor, so they seed the remainder
                    div_req.load     = 1'b1;
                    div_req.wide     = 1'b0;
                    div_req.rem_init = n_reg[63:32];
                    div_req.dividend = {n_reg[31:0], 32'b0};
                    div_req.divisor  = freq_reg;
                    state_next       = ST_CONV_DIV;
                end
            end
            ST_CONV_DIV:
            begin
                if (div_rsp.done)
                begin
                    store_en  = 1'b1;
                    store_val = div_rsp.quotient[30:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (store_en)
        begin
            case (idx_reg)
                CONV_LAST: acc_next.last_us    = store_val;
                CONV_AVG:  acc_next.average_us = store_val;
                default:   acc_next.max_us     = store_val;
            endcase
            if (idx_reg == CONV_MAX)
            begin
                result_next = acc_next;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            else
            begin
                idx_next   = idx_reg + 2'd1;
                state_next = ST_CONV_LO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= CONV_LAST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        entry_reg  <= entry_next;
        d_reg      <= d_next;
        avg_reg    <= avg_next;
        p_lo_reg   <= p_lo_next;
        p_hi_reg   <= p_hi_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[sv/lst_chk.sv]
// ----------------------------------------------------------------------------
// lst_chk
// Port-level checks of the command/result sequencing of the table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lst_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted command makes the block busy in the next cycle
    `LST_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // a result beat only ends a busy period
    `LST_ASSERT_SAME(a_done_after_busy, done, $past(busy))

    // one result beat per command
    `LST_ASSERT_NEXT(a_done_single, done, !done)

endmodule

bind latency_stats_table lst_chk u_lst_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

[verif/latency_stats_table_tb.sv]
// ----------------------------------------------------------------------------
// latency_stats_table_tb
// Self-checking bench for the latency statistics table. Commands go in with
// random gaps; a scoreboard keeps its own copy of every slot and of the
// registers, predicts each reply beat and checks it field by field. The run
// walks through several register settings, including disabled, zero
// frequency and out-of-range clear counts.
// ----------------------------------------------------------------------------
module latency_stats_table_tb;
    import lst_pkg::*;

    localparam int          SLOTS       = 32;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    // ------------------------------------------------------------------------
    // Slot statistics scoreboard
    // ------------------------------------------------------------------------
    class stats_scoreboard;
        logic        en;
        logic [5:0]  slots_used;
        logic [31:0] freq;
        logic [63:0] t_start [SLOTS];
        logic [63:0] t_end   [SLOTS];
        logic [63:0] span_sum[SLOTS];
        logic [63:0] span_max[SLOTS];
        logic [31:0] samples [SLOTS];
        lst_out_t    pending[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned busy_queries;
        int unsigned saturated;

        function new();
            en         = 1'b0;
            slots_used = 6'd32;
            freq       = '0;
            for (int i = 0; i < SLOTS; i++)
                wipe(i);
            errors       = 0;
            checked      = 0;
            busy_queries = 0;
            saturated    = 0;
        endfunction

        function void wipe(int i);
            t_start[i]  = '0;
            t_end[i]    = '0;
            span_sum[i] = '0;
            span_max[i] = '0;
            samples[i]  = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_ENABLE:    en = data[0];
                CFG_SLOTS:     slots_used = data[5:0];
                CFG_FREQUENCY: freq = data;
                default: ;
            endcase
        endfunction

        // exact floor(ticks * 1e6 / freq), clipped to 31 bits
        function logic [30:0] to_us(logic [63:0] ticks);
            logic [127:0] scaled;
            if (freq == 0)
                return '0;
            scaled = ({64'd0, ticks} * {108'd0, US_PER_S}) / {96'd0, freq};
            if (scaled > {97'd0, US_LIMIT})
            begin
                saturated++;
                return US_LIMIT;
            end
            return scaled[30:0];
        endfunction

        function void note_request(lst_in_t item);
            lst_out_t    reply;
            logic [63:0] span;
            int          n;
            int          s;
            reply = '0;
            s = int'(item.slot);
            if (en)
            begin
                if (lst_cmd_t'(item.cmd) == CMD_CLEAR)
                begin
                    n = (slots_used > SLOTS) ? SLOTS : int'(slots_used);
                    for (int i = 0; i < n; i++)
                        wipe(i);
                end
                else if (s < SLOTS)
                begin
                    case (lst_cmd_t'(item.cmd))
                        CMD_START: t_start[s] = item.timestamp;
                        CMD_END:
                        begin
                            t_end[s] = item.timestamp;
                            span = item.timestamp - t_start[s];
                            span_sum[s] += span;
                            if (samples[s] != '1)
                                samples[s]++;
                            if (span_max[s] < span)
                                span_max[s] = span;
                        end
                        CMD_QUERY:
                        begin
                            reply.last_us = to_us(t_end[s] - t_start[s]);
                            if (samples[s] != 0)
                                reply.average_us = to_us(span_sum[s] / {32'd0, samples[s]});
                            reply.max_us = to_us(span_max[s]);
                            if (reply != '0)
                                busy_queries++;
                        end
                        default: ;
                    endcase
                end
            end
            pending.push_back(reply);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_result(lst_out_t got);
            lst_out_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result beat %h with nothing pending", got));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.last_us !== want.last_us)
                report($sformatf("last_us got %0d want %0d", got.last_us, want.last_us));
            if (got.average_us !== want.average_us)
                report($sformatf("average_us got %0d want %0d",
                                 got.average_us, want.average_us));
            if (got.max_us !== want.max_us)
                report($sformatf("max_us got %0d want %0d", got.max_us, want.max_us));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    lst_in_t     request   = '0;
    logic        done;
    lst_out_t    result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    stats_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned op_count[4] = '{0, 0, 0, 0};
    int unsigned settings = 0;
    logic [63:0] tick_now;
    bit          burst = 1'b0;

    latency_stats_table #(.SLOTS(SLOTS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // only between phases, once every reply beat is in
    task automatic configure(logic en, logic [5:0] n, logic [31:0] f);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        write_reg(CFG_ENABLE, {31'd0, en});
        write_reg(CFG_SLOTS, {26'd0, n});
        write_reg(CFG_FREQUENCY, f);
        cfg_valid <= 1'b0;
        settings++;
        @(posedge clk);
    endtask

    // one command beat, then a random gap (start stays high when there is none)
    task automatic issue(lst_cmd_t op, logic [4:0] s, logic [63:0] ts);
        lst_in_t     item;
        int unsigned r;
        int unsigned gap;
        item.cmd       = op;
        item.slot      = s;
        item.timestamp = ts;
        start   <= 1'b1;
        request <= item;
        do @(posedge clk); while (busy);
        sb.note_request(item);
        op_count[op]++;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 20);
        else
            gap = $urandom_range(30, 150);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // durations: short, 32-bit, full 64-bit (wraps), and right at the 2^31-1 us edge
    function automatic logic [63:0] pick_span(logic [31:0] f);
        int unsigned r;
        logic [63:0] edge_ticks;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 64'($urandom_range(0, 65535));
        if (r < 65)
            return 64'($urandom);
        if (r < 80)
            return {$urandom, $urandom};
        edge_ticks = (64'(US_LIMIT) * 64'(f) + 64'd999999) / 64'd1000000;
        return edge_ticks - 64'd1 + 64'($urandom_range(0, 2));
    endfunction

    task automatic run_directed();
        issue(CMD_QUERY, 5'd0, 64'd0);
        issue(CMD_START, 5'd0, 64'd0);
        issue(CMD_END, 5'd0, 64'd100);
        issue(CMD_QUERY, 5'd0, 64'd200);
        // end stamp below start: duration wraps
        issue(CMD_START, 5'd31, '1);
        issue(CMD_END, 5'd31, 64'd5);
        issue(CMD_QUERY, 5'd31, 64'd6);
        issue(CMD_START, 5'd1, 64'd10);
        issue(CMD_END, 5'd1, 64'd9);
        issue(CMD_QUERY, 5'd1, 64'd11);
        // exactly the largest value, then one past it
        issue(CMD_END, 5'd2, 64'd2147483647);
        issue(CMD_QUERY, 5'd2, 64'd0);
        issue(CMD_START, 5'd2, 64'h8000_0000_0000_0000);
        issue(CMD_END, 5'd2, 64'h8000_0000_8000_0000);
        issue(CMD_QUERY, 5'd2, 64'h8000_0000_8000_0001);
        issue(CMD_CLEAR, 5'd7, 64'h5A5A_A5A5_5A5A_A5A5);
        issue(CMD_QUERY, 5'd0, 64'd0);
        issue(CMD_QUERY, 5'd31, 64'd0);
        start <= 1'b0;
    endtask

    task automatic run_random(int unsigned target);
        int unsigned sent;
        int unsigned r;
        int unsigned reps;
        logic [4:0]  s;
        sent = 0;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            s = 5'($urandom);
            burst = ($urandom_range(0, 4) == 0);
            if (r < 70)
            begin
                reps = $urandom_range(1, 4);
                repeat (reps)
                begin
                    issue(CMD_START, s, tick_now);
                    tick_now += pick_span(sb.freq);
                    issue(CMD_END, s, tick_now);
                    tick_now += 64'($urandom_range(0, 1000));
                end
                issue(CMD_QUERY, s, tick_now);
                sent += 2 * reps + 1;
            end
            else if (r < 76)
            begin
                issue(CMD_CLEAR, s, {$urandom, $urandom});
                issue(CMD_QUERY, 5'($urandom), {$urandom, $urandom});
                sent += 2;
            end
            else
            begin
                issue(lst_cmd_t'($urandom_range(0, 3)), s, {$urandom, $urandom});
                sent++;
            end
        end
        burst = 1'b0;
        start <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tick_now = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        configure(1'b1, 6'd32, 32'd1000000);
        run_directed();

        configure(1'b0, 6'd32, 32'd1000000);
        run_random(60);
        configure(1'b1, 6'd0, 32'd32768);
        run_random(300);
        configure(1'b1, 6'd63, 32'd0);
        run_random(160);
        configure(1'b1, 6'd1, 32'hFFFF_FFFF);
        run_random(260);
        configure(1'b1, 6'd16, 32'd1);
        run_random(260);
        configure(1'b1, 6'd32, $urandom);
        run_random(300);
        configure(1'b1, 6'd33, 32'd1000000);
        run_random(300);
        configure(1'b1, 6'($urandom_range(1, 32)), $urandom);
        run_random(180);

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("tb: %0d commands (%0d clear, %0d start, %0d end, %0d query), %0d settings",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[CMD_CLEAR], op_count[CMD_START], op_count[CMD_END],
                 op_count[CMD_QUERY], settings);
        $display("tb: %0d replies checked, %0d nonzero queries, %0d clipped values, %0d errors",
                 sb.checked, sb.busy_queries, sb.saturated, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/lst_pkg.sv
sv/lst_div.sv
sv/latency_stats_table.sv
sv/lst_chk.sv
verif/latency_stats_table_tb.sv
